[src/aes_pkg.sv]
// AES-128 package: types, S-box tables and GF(2^8) helpers.
// Used by every module of the aes128_block_cipher block.
`default_nettype none
package aes_pkg;

  localparam int Rounds = 10;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   dec;
    block_t state;
    block_t key;
  } stage_t;

  localparam logic [7:0] Rcon [Rounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] byte_of(input block_t b, input int n);
    return b[127 - 8*n -: 8];
  endfunction

  // Next round key; k is the round-r key, result is round r+1.
  function automatic block_t key_fwd(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // Previous round key; k is round r+1, rc that of round r+1.
  function automatic block_t key_bwd(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    w3 = w3 ^ w2; w2 = w2 ^ w1; w1 = w1 ^ w0;
    t = {Sbox[w3[23:16]] ^ rc, Sbox[w3[15:8]], Sbox[w3[7:0]], Sbox[w3[31:24]]};
    w0 = w0 ^ t;
    return {w0, w1, w2, w3};
  endfunction

  function automatic block_t mix_fwd(input block_t b);
    block_t o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(b, 4*c); a1 = byte_of(b, 4*c+1);
      a2 = byte_of(b, 4*c+2); a3 = byte_of(b, 4*c+3);
      o[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      o[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      o[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      o[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return o;
  endfunction

  // Inverse mix as a pre-step (4,5 multiply) followed by the forward mix.
  function automatic block_t mix_inv(input block_t b);
    block_t p;
    logic [7:0] a0, a1, a2, a3, u, v;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(b, 4*c); a1 = byte_of(b, 4*c+1);
      a2 = byte_of(b, 4*c+2); a3 = byte_of(b, 4*c+3);
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      p[127 - 32*c -: 8] = a0 ^ u;
      p[119 - 32*c -: 8] = a1 ^ v;
      p[111 - 32*c -: 8] = a2 ^ u;
      p[103 - 32*c -: 8] = a3 ^ v;
    end
    return mix_fwd(p);
  endfunction

  function automatic block_t sub_shift_fwd(input block_t b);
    block_t o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        o[127 - 8*(r + 4*c) -: 8] = Sbox[byte_of(b, r + 4*((c + r) % 4))];
    return o;
  endfunction

  function automatic block_t sub_shift_inv(input block_t b);
    block_t o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        o[127 - 8*(r + 4*c) -: 8] = InvSbox[byte_of(b, r + 4*((c + 3*r) % 4))];
    return o;
  endfunction

endpackage
`default_nettype wire

[src/aes_if.sv]
// Valid/ready channel carrying one AES request or result.
// Depends on nothing.
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] data_in_hi;
  logic [63:0] data_in_lo;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  modport source (output valid, cmd, data_in_hi, data_in_lo, key_hi, key_lo, input ready);
  modport sink (input valid, cmd, data_in_hi, data_in_lo, key_hi, key_lo, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out_hi;
  logic [63:0] data_out_lo;
  modport source (output valid, data_out_hi, data_out_lo, input ready);
  modport sink (input valid, data_out_hi, data_out_lo, output ready);
endinterface
`default_nettype wire

[src/aes128_block_cipher.sv]
// aes128_block_cipher top level: key-prep pipeline, ten round stages, output reg.
// Depends on aes_pkg, aes_if, aes_prep, aes_round.
// Pipeline: 10 key-prep stages, 10 round stages and 1 output register between
// accepted request and result valid. Throughput: one block per cycle; the
// whole pipe advances whenever the output register is empty or being taken.
// Reset (rst, synchronous) clears all valid bits; no data is held.
`default_nettype none
module aes128_block_cipher
  import aes_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  aes_in_if.sink    req,
  aes_out_if.source rsp
);

  logic   en;
  logic   pv;
  stage_t pin, pd;
  logic   rv [Rounds+1];
  stage_t rd [Rounds+1];

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign pin.dec   = req.cmd;
  assign pin.state = {req.data_in_hi, req.data_in_lo};
  assign pin.key   = {req.key_hi, req.key_lo};

  aes_prep u_prep (
    .clk, .rst, .en,
    .in_valid (req.valid),
    .in_data  (pin),
    .out_valid(pv),
    .out_data (pd)
  );

  assign rv[0] = pv;
  assign rd[0] = pd;

  for (genvar i = 0; i < Rounds; i++) begin : g_rnd
    aes_round u_round (
      .clk, .rst, .en,
      .last     (i == Rounds - 1),
      .rc_fwd   (Rcon[i]),
      .rc_bwd   (Rcon[Rounds - 1 - i]),
      .in_valid (rv[i]),
      .in_data  (rd[i]),
      .out_valid(rv[i+1]),
      .out_data (rd[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= rv[Rounds];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.data_out_hi <= rd[Rounds].state[127:64];
      rsp.data_out_lo <= rd[Rounds].state[63:0];
    end
  end

endmodule
`default_nettype wire

[src/aes_round.sv]
// One registered AES round stage (forward or inverse) with on-the-fly key step.
// Depends on aes_pkg.
`default_nettype none
module aes_round
  import aes_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic       last,
  input  wire logic [7:0] rc_fwd,
  input  wire logic [7:0] rc_bwd,
  input  wire logic       in_valid,
  input  wire stage_t     in_data,
  output      logic       out_valid,
  output      stage_t     out_data
);

  stage_t nxt;
  block_t kf, kb, sf, si;

  always_comb begin
    kf = key_fwd(in_data.key, rc_fwd);
    kb = key_bwd(in_data.key, rc_bwd);
    sf = sub_shift_fwd(in_data.state);
    si = sub_shift_inv(in_data.state) ^ kb;
    nxt.dec = in_data.dec;
    if (in_data.dec) begin
      nxt.key   = kb;
      nxt.state = last ? si : mix_inv(si);
    end else begin
      nxt.key   = kf;
      nxt.state = (last ? sf : mix_fwd(sf)) ^ kf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

[src/aes_prep.sv]
// Input stage: initial key addition, and full forward key expansion for decrypt.
// Depends on aes_pkg.
`default_nettype none
module aes_prep
  import aes_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   in_valid,
  input  wire stage_t in_data,
  output      logic   out_valid,
  output      stage_t out_data
);

  // Decrypt needs the last round key; expand it over pipelined steps.
  logic   v   [Rounds+1];
  stage_t s   [Rounds+1];

  // Original key rides along for encrypt items in a delay line.
  block_t okey [Rounds];

  assign v[0] = in_valid;
  assign s[0] = in_data;

  assign okey[0] = in_data.key;
  for (genvar j = 1; j < Rounds; j++) begin : g_ok
    always_ff @(posedge clk) begin
      if (en) begin
        okey[j] <= okey[j-1];
      end
    end
  end

  for (genvar i = 0; i < Rounds; i++) begin : g_exp
    stage_t n;
    always_comb begin
      n = s[i];
      n.key = key_fwd(s[i].key, Rcon[i]);
      if (i == Rounds - 1) begin
        n.state = s[i].dec ? (s[i].state ^ n.key) : (s[i].state ^ okey[i]);
        n.key   = s[i].dec ? n.key : okey[i];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s[i+1] <= n;
      end
    end
  end

  assign out_valid = v[Rounds];
  assign out_data  = s[Rounds];

endmodule
`default_nettype wire

[sim/tb_aes_if.sv]
// Cipher predictor helpers for tb_top: GF(2^8) multiply and S-box generation.
// Depends on nothing.
`timescale 1ns / 1ps
package tb_aes_pred_pkg;

  typedef logic [127:0] blk_t;

  function automatic logic [7:0] gmul2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) acc ^= a;
      a = gmul2(a);
      b = b >> 1;
    end
    return acc;
  endfunction

  // forward S-box computed from field inverse and affine map
  function automatic logic [7:0] fsub(input logic [7:0] x);
    logic [7:0] inv, r;
    inv = 8'h00;
    if (x != 0)
      for (int i = 1; i < 256; i++)
        if (gmul(x, i[7:0]) == 8'h01) inv = i[7:0];
    r = 8'h63;
    for (int i = 0; i < 8; i++)
      r[i] = r[i] ^ inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8];
    return r;
  endfunction

endpackage

[sim/tb_top.sv]
// Self-checking bench for aes128_block_cipher: random and directed AES requests.
// Depends on aes_pkg, aes_if, tb_aes_pred_pkg and the cipher RTL.
`timescale 1ns / 1ps
module tb_top;
  import tb_aes_pred_pkg::*;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  aes_in_if req ();
  aes_out_if rsp ();

  aes128_block_cipher dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] fbox [256];
  logic [7:0] ibox [256];
  cipher_res_t cipher_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  function automatic logic [7:0] bget(input blk_t b, input int n);
    return b[127 - 8*n -: 8];
  endfunction

  function automatic blk_t shift_sub(input blk_t b, input int dir, input bit dec);
    blk_t o;
    logic [7:0] x;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        x = bget(b, r + 4*((c + dir*r) & 3));
        o[127 - 8*(r + 4*c) -: 8] = dec ? ibox[x] : fbox[x];
      end
    return o;
  endfunction

  function automatic blk_t mix(input blk_t b, input bit dec);
    blk_t o;
    logic [7:0] cf [4];
    logic [7:0] col [4];
    logic [7:0] v;
    if (dec) cf = '{8'd14, 8'd11, 8'd13, 8'd9};
    else cf = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = bget(b, 4*c + r);
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int j = 0; j < 4; j++) v ^= gmul(col[j], cf[(4 + j - r) & 3]);
        o[127 - 8*(4*c + r) -: 8] = v;
      end
    end
    return o;
  endfunction

  function automatic cipher_res_t aes_predict(input logic dec, input blk_t data,
                                              input blk_t key);
    blk_t rk [11];
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0] rc;
    blk_t s;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[127 - 32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fbox[t[23:16]] ^ rc, fbox[t[15:8]], fbox[t[7:0]], fbox[t[31:24]]};
        rc = gmul2(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    if (!dec) begin
      s = data ^ rk[0];
      for (int r = 1; r <= 10; r++) begin
        s = shift_sub(s, 1, 1'b0);
        if (r != 10) s = mix(s, 1'b0);
        s ^= rk[r];
      end
    end else begin
      s = data ^ rk[10];
      for (int r = 9; r >= 0; r--) begin
        s = shift_sub(s, 3, 1'b1) ^ rk[r];
        if (r != 0) s = mix(s, 1'b1);
      end
    end
    return '{hi: s[127:64], lo: s[63:0]};
  endfunction

  task automatic send_request(input logic dec, input blk_t data, input blk_t key);
    req.valid <= 1'b1;
    req.cmd <= dec;
    req.data_in_hi <= data[127:64];
    req.data_in_lo <= data[63:0];
    req.key_hi <= key[127:64];
    req.key_lo <= key[63:0];
    do @(posedge clk); while (!req.ready);
    cipher_q.push_back(aes_predict(dec, data, key));
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  function automatic blk_t rand_blk();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic test_known_vector();
    // FIPS-197 appendix C.1 in both directions
    send_request(1'b0, 128'h00112233445566778899aabbccddeeff,
                 128'h000102030405060708090a0b0c0d0e0f);
    send_request(1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a,
                 128'h000102030405060708090a0b0c0d0e0f);
  endtask

  task automatic test_extremes();
    blk_t pats [4];
    pats = '{128'h0, {128{1'b1}}, {16{8'haa}}, {16{8'h55}}};
    for (int d = 0; d < 2; d++)
      for (int i = 0; i < 4; i++) send_request(d[0], pats[i], pats[(i + d) % 4]);
  endtask

  task automatic test_walking_bits();
    for (int i = 0; i < 8; i++)
      send_request(i[0], 128'h1 << (i * 17), ~(128'h1 << (127 - i * 13)));
  endtask

  task automatic test_random(input int n);
    blk_t k, d, c;
    for (int i = 0; i < n; i++) begin
      k = rand_blk();
      d = rand_blk();
      if (i >= n - 60) quiet = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        // round trip: encrypt, then decrypt the predicted ciphertext with the same key
        send_request(1'b0, d, k);
        c = {cipher_q[$].hi, cipher_q[$].lo};
        send_request(1'b1, c, k);
        i++;
      end else
        send_request($urandom_range(0, 1), d, k);
    end
  endtask

  always @(posedge clk) begin
    cipher_res_t exp_r;
    if (!rst && rsp.valid && rsp.ready) begin
      if (cipher_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h", rsp.data_out_hi, rsp.data_out_lo);
      end else begin
        exp_r = cipher_q.pop_front();
        if (rsp.data_out_hi !== exp_r.hi || rsp.data_out_lo !== exp_r.lo) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h %h got %h %h", exp_r.hi, exp_r.lo,
                     rsp.data_out_hi, rsp.data_out_lo);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (quiet || $urandom_range(0, 5) != 0) rsp.ready <= 1'b1;
    else begin
      rsp.ready <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) fbox[i] = fsub(i[7:0]);
    for (int i = 0; i < 256; i++) ibox[fbox[i]] = i[7:0];
    req.valid = 1'b0;
    req.cmd = 1'b0;
    req.data_in_hi = '0;
    req.data_in_lo = '0;
    req.key_hi = '0;
    req.key_lo = '0;
    rsp.ready = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_known_vector();
    test_extremes();
    test_walking_bits();
    test_random(600);
    req.valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
